### design/assert_macros.svh
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock
`define CHK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent in the same cycle as the antecedent
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ple_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OP_W = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int ST_W = 2;
  localparam int IN_TDATA_W = ((OP_W + VAL_W + POS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS  = 2'd0,
    OP_DEL  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/ple_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  ple_pkg::cell_ctrl_t               ctrl,
  input  logic signed [ple_pkg::VAL_W-1:0]  ins_value,
  input  logic signed [ple_pkg::VAL_W-1:0]  left,
  input  logic signed [ple_pkg::VAL_W-1:0]  right,
  output logic signed [ple_pkg::VAL_W-1:0]  q
);
  import ple_pkg::*;

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic signed [VAL_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctrl.op)
      CELL_INS: begin
        if (IDX > ctrl.idx) begin
          q_next = left;
        end else if (IDX == ctrl.idx) begin
          q_next = ins_value;
        end
      end
      CELL_DEL: begin
        if (IDX >= ctrl.idx) begin
          q_next = right;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

`default_nettype wire

### design/ple_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module ple_chain #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  ple_pkg::cell_ctrl_t               ctrl,
  input  logic signed [ple_pkg::VAL_W-1:0]  ins_value,
  output logic signed [ple_pkg::VAL_W-1:0]  rd_data
);
  import ple_pkg::*;

  logic signed [VAL_W-1:0] q     [CAPACITY];
  logic signed [VAL_W-1:0] left  [CAPACITY];
  logic signed [VAL_W-1:0] right [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    if (g == 0) begin : g_head
      assign left[g] = '0;
    end else begin : g_mid_l
      assign left[g] = q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right[g] = '0;
    end else begin : g_mid_r
      assign right[g] = q[g+1];
    end

    ple_cell #(
      .INDEX(g)
    ) u_slot (
      .clk(clk),
      .ctrl(ctrl),
      .ins_value(ins_value),
      .left(left[g]),
      .right(right[g]),
      .q(q[g])
    );
  end

  // and-or select of the addressed slot
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (POS_W'(i) == ctrl.idx) begin
        rd_data = rd_data | q[i];
      end
    end
  end

endmodule

`default_nettype wire

### design/positional_list_engine.sv
// channel  dir  tdata fields (low bit first)                  tuser  tlast
// s_*      in   op[1:0] value[33:2] position[41:34], pad 48    -      -
// m_*      out  status[1:0] item_value[33:2] count[+CNT_W]     -      -
//
// one item per cycle while the result is taken; its result is registered and shows in the cycle after accept
// the slots of the cell row at or past the position shift toward or away from it together
// s_tready drops only while the output register holds an item not yet taken
// rst clears the fill count and output valid; slot contents need no reset
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int OUT_W    = ((ple_pkg::ST_W + ple_pkg::VAL_W + CNT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ple_pkg::IN_TDATA_W-1:0] s_tdata,   // op, value, position
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [OUT_W-1:0]               m_tdata    // status, item_value, count
);
  import ple_pkg::*;

  localparam int CMP_W = CNT_W + POS_W;

  logic                    accept;
  op_t                     in_op;
  logic signed [VAL_W-1:0] in_value;
  logic [POS_W-1:0]        in_pos;
  logic [CMP_W-1:0]        pos_ext;
  logic [CMP_W-1:0]        fill_ext;
  logic                    is_full;
  logic                    is_empty;
  logic                    past_end;

  logic [CNT_W-1:0]        fill;
  logic [CNT_W-1:0]        fill_next;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] rd_data;
  status_t                 status_next;
  logic signed [VAL_W-1:0] value_next;

  logic                    out_valid;
  status_t                 out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [CNT_W-1:0]        out_count;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign in_op    = op_t'(s_tdata[OP_W-1:0]);
  assign in_value = s_tdata[OP_W +: VAL_W];
  assign in_pos   = s_tdata[OP_W+VAL_W +: POS_W];

  assign pos_ext  = CMP_W'(in_pos);
  assign fill_ext = CMP_W'(fill);
  assign is_full  = (fill == CNT_W'(CAPACITY));
  assign is_empty = (fill == '0);
  assign past_end = (pos_ext > fill_ext);

  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.idx    = in_pos - POS_W'(1);
    status_next = ST_OK;
    value_next  = '0;
    fill_next   = fill;
    unique case (in_op) inside
      OP_INS: begin
        ctrl.idx = past_end ? fill_ext[POS_W-1:0] : in_pos;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.op   = CELL_INS;
          fill_next = fill + CNT_W'(1);
        end
      end
      OP_DEL, OP_READ: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (in_pos == '0 || past_end) begin
          status_next = ST_OOB;
        end else begin
          value_next = rd_data;
          if (in_op == OP_DEL) begin
            ctrl.op   = CELL_DEL;
            fill_next = fill - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  ple_chain #(
    .CAPACITY(CAPACITY)
  ) u_chain (
    .clk(clk),
    .ctrl(ctrl),
    .ins_value(in_value),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_value  <= value_next;
      out_count  <= fill_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_count, out_value, out_status});

endmodule

`default_nettype wire

### design/ple_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ple_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int OUT_W    = ((ple_pkg::ST_W + ple_pkg::VAL_W + CNT_W + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [OUT_W-1:0]               m_tdata
);
  import ple_pkg::*;

  logic [ST_W-1:0]  st;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] cnt;

  assign st  = m_tdata[ST_W-1:0];
  assign val = m_tdata[ST_W +: VAL_W];
  assign cnt = m_tdata[ST_W+VAL_W +: CNT_W];

  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
  `CHK_SAME(a_err_zero, m_tvalid && st != ST_OK, val == '0, "value on refused item")
  `CHK_SAME(a_in_stall, s_tvalid && !s_tready, m_tvalid, "input stalled with output free")
  `CHK_SAME(a_full_cnt, m_tvalid && st == ST_FULL, cnt == CNT_W'(CAPACITY), "full with room")
  `CHK_SAME(a_empty_cnt, m_tvalid && st == ST_EMPTY, cnt == '0, "empty with items")

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY(CAPACITY),
  .CNT_W(CNT_W),
  .OUT_W(OUT_W)
) u_ple_checker (.*);

`default_nettype wire

### dv/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int LIST_DEPTH = CAPACITY_DEF;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int OUT_W = ((ST_W + VAL_W + CNT_W + 7) / 8) * 8;
  localparam int PAD_W = IN_TDATA_W - OP_W - VAL_W - POS_W;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_ITEMS = 200;
  localparam int LONG_HOLD = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] item_value;
    logic [CNT_W-1:0] count;
  } list_result_t;

  class list_scoreboard;
    logic [VAL_W-1:0] slots [LIST_DEPTH];
    int unsigned fill;
    list_result_t pending_q [$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < 50) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // list model: one result per accepted item
    function void note_item(op_t op, logic [VAL_W-1:0] value, logic [POS_W-1:0] position);
      list_result_t r;
      int unsigned p;
      int unsigned i;
      r.status = ST_OK;
      r.item_value = '0;
      case (op)
        OP_INS: begin
          if (fill >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            p = (position > fill) ? fill : position;
            for (i = fill; i > p; i--) slots[i] = slots[i-1];
            slots[p] = value;
            fill++;
          end
        end
        OP_DEL, OP_READ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (position == 0 || position > fill) begin
            r.status = ST_OOB;
          end else begin
            r.item_value = slots[position-1];
            if (op == OP_DEL) begin
              for (i = position - 1; i + 1 < fill; i++) slots[i] = slots[i+1];
              fill--;
            end
          end
        end
        default: ;
      endcase
      r.count = fill[CNT_W-1:0];
      pending_q.push_back(r);
    endfunction

    task check_result(logic [OUT_W-1:0] word);
      list_result_t want;
      logic [ST_W-1:0] got_status;
      logic [VAL_W-1:0] got_value;
      logic [CNT_W-1:0] got_count;
      got_status = word[ST_W-1:0];
      got_value = word[ST_W +: VAL_W];
      got_count = word[ST_W+VAL_W +: CNT_W];
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected item status=%0d value=%h count=%0d",
                         got_status, got_value, got_count));
        return;
      end
      want = pending_q.pop_front();
      if (got_status != want.status)
        report($sformatf("status %0d, want %0d", got_status, want.status));
      if (got_value != want.item_value)
        report($sformatf("item_value %h, want %h", got_value, want.item_value));
      if (got_count != want.count)
        report($sformatf("count %0d, want %0d", got_count, want.count));
    endtask
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;   // op, value, position, zero pad
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;        // status, item_value, count, zero pad

  list_scoreboard sb;
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_request;
  int cycles;

  positional_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_item(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W +: VAL_W],
                     s_tdata[OP_W+VAL_W +: POS_W]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata);
    end
  end

  // result side
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task send_item(op_t op, logic [VAL_W-1:0] value, logic [POS_W-1:0] position);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{PAD_W{1'b0}}, position, value, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int sent;
    int k;
    int r;
    int unsigned cur_fill;
    bit grow;
    op_t op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;

    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cycles = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, single element, head/tail/middle, bounds, unused op, full
    send_item(OP_READ, 32'h0000_0000, 8'd1);
    send_item(OP_DEL, 32'h1234_5678, 8'd1);
    send_item(OP_INS, 32'h0000_0005, 8'd200);
    send_item(OP_DEL, 32'h0000_0000, 8'd1);
    send_item(OP_READ, 32'h0000_0000, 8'd1);
    send_item(OP_INS, 32'h8000_0000, 8'd9);
    send_item(OP_INS, 32'h7fff_ffff, 8'd0);
    send_item(OP_INS, 32'hffff_ffff, 8'd255);
    send_item(OP_INS, 32'h0000_0000, 8'd1);
    send_item(OP_READ, 32'h0000_0000, 8'd0);
    send_item(OP_DEL, 32'h0000_0000, 8'd255);
    send_item(OP_NONE, 32'hdead_beef, 8'd3);
    for (k = 0; k < LIST_DEPTH - 4; k++)
      send_item(OP_INS, $urandom, 8'((k * 5) % 17));
    send_item(OP_INS, 32'h5555_aaaa, 8'd0);
    send_item(OP_DEL, 32'h0000_0000, 8'd16);

    sent = 0;
    k = 0;
    grow = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (k % 100 == 0) begin
        grow = $urandom_range(0, 1);
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (k == 300 || k == 1000) hold_request = 1'b1;
      if (k == 700) begin
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending_q.size() != 0);
      end

      cur_fill = sb.fill;
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_NONE;
      else if (r < (grow ? 62 : 30)) op = OP_INS;
      else if (r < (grow ? 80 : 78)) op = OP_DEL;
      else op = OP_READ;

      case ($urandom_range(0, 11))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        2: value = 32'hffff_ffff;
        3: value = 32'h0000_0000;
        default: value = $urandom;
      endcase

      case ($urandom_range(0, 19))
        0: position = 8'd0;
        1: position = 8'd255;
        2: position = 8'($urandom_range(0, 255));
        default: position = 8'($urandom_range(0, cur_fill + 1));
      endcase

      send_item(op, value, position);
      if (op != OP_NONE) sent++;
      k++;
    end
    s_tvalid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/ple_pkg.sv
design/ple_cell.sv
design/ple_chain.sv
design/positional_list_engine.sv
design/ple_checker.sv
dv/tb_positional_list_engine.sv
